// File: rtl/ppfa_pkg.sv
// Shared constants and types for the particle pair force accumulator.
`default_nettype none

package ppfa_pkg;

  // Default geometry and species count
  localparam int unsigned SCREEN_WIDTH_DEF  = 1920;
  localparam int unsigned SCREEN_HEIGHT_DEF = 1080;
  localparam int unsigned KINDS_DEF         = 6;

  // Field widths
  localparam int unsigned POS_W   = 15;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned WRAP_W  = 2;
  localparam int unsigned FORCE_W = 24;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Datapath widths
  localparam int unsigned DELTA_W    = 19;  // signed neighbour offset
  localparam int unsigned MAG_W      = 17;  // offset magnitude
  localparam int unsigned RAD_W      = 36;  // squared distance
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned DIVIDEND_W = 50;
  localparam int unsigned DIVISOR_W  = 35;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned MUL_A_W    = 27;
  localparam int unsigned MUL_B_W    = 18;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned F_W        = QUOT_W + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER  = 3'd0,
    REG_OUTER  = 3'd1,
    REG_COEF0  = 3'd2,
    REG_COEF1  = 3'd3,
    REG_COEF2  = 3'd4,
    REG_COEF3  = 3'd5,
    REG_COEF4  = 3'd6
  } reg_idx_e;

  localparam logic [POS_W-1:0] INNER_RST = 15'd320;
  localparam logic [POS_W-1:0] OUTER_RST = 15'd1280;

endpackage

`default_nettype wire

// File: rtl/ppfa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module ppfa_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [ppfa_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [ppfa_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                                  done_o,
  output logic [ppfa_pkg::QUOT_W-1:0]           quot_o
);

  localparam int unsigned CNT_W = $clog2(ppfa_pkg::QUOT_W + 1);

  logic [ppfa_pkg::DIVIDEND_W-1:0] rem_q, rem_d;
  logic [ppfa_pkg::DIVIDEND_W-1:0] dsh_q, dsh_d;
  logic [ppfa_pkg::QUOT_W-1:0]     quot_q, quot_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;

  // One compare and subtract against the shifted divisor per step
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = {divisor_i, (ppfa_pkg::QUOT_W - 1)'(0)};
      quot_d = '0;
      cnt_d  = CNT_W'(ppfa_pkg::QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[ppfa_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[ppfa_pkg::QUOT_W-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: rtl/ppfa_sqrt.sv
// Iterative integer square root, one root bit per cycle.
`default_nettype none

module ppfa_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ppfa_pkg::RAD_W-1:0]   rad_i,
  output logic                              done_o,
  output logic [ppfa_pkg::ROOT_W-1:0]       root_o
);

  localparam int unsigned CNT_W = $clog2(ppfa_pkg::ROOT_W + 1);

  logic [ppfa_pkg::RAD_W-1:0] val_q, val_d;
  logic [ppfa_pkg::RAD_W-1:0] root_q, root_d;
  logic [ppfa_pkg::RAD_W-1:0] bit_q, bit_d;
  logic [ppfa_pkg::RAD_W-1:0] trial;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  assign trial = root_q + bit_q;

  // Take one root bit per step
  always_comb begin
    val_d  = val_q;
    root_d = root_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = rad_i;
      root_d = '0;
      bit_d  = ppfa_pkg::RAD_W'(1) << (ppfa_pkg::RAD_W - 2);
      cnt_d  = CNT_W'(ppfa_pkg::ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (val_q >= trial) begin
        val_d  = val_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[ppfa_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/particle_pair_force_accumulator.sv
// A self, zero-distance or out-of-range pair ends after the square root, a repulsion pair
// adds two divisions and an attraction pair four; the next beat is taken once the pair is summed.
// The time per pair is set by the 18-step square root and by up to four 16-step divisions;
// all divisions run through one shared divider and all products through one shared multiplier.
// A finished sum waits in an output register while the next pairs are taken.
// Reset clears the sums and the output valid, and loads inner 320, outer 1280, coefficients 0.
`default_nettype none

module particle_pair_force_accumulator #(
  parameter int unsigned SCREEN_WIDTH  = ppfa_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = ppfa_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned KINDS         = ppfa_pkg::KINDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [ppfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ppfa_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Pair input
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // self_x, self_y, self_kind, other_x, other_y, other_kind, wrap_x, wrap_y, pad
  input  wire logic [71:0]                     s_axis_tdata,
  // is_self
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  // Force output
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // force_x, force_y
  output logic [47:0]                          m_axis_tdata
);

  localparam int unsigned DW = ppfa_pkg::DELTA_W;
  localparam int unsigned MW = ppfa_pkg::MAG_W;
  localparam int unsigned PW = ppfa_pkg::POS_W;
  localparam int unsigned RW = ppfa_pkg::ROOT_W;
  localparam logic signed [DW-1:0] WX1 = DW'(SCREEN_WIDTH * 16);
  localparam logic signed [DW-1:0] WY1 = DW'(SCREEN_HEIGHT * 16);
  localparam logic [ppfa_pkg::DIVISOR_W-1:0] BHASK_K = ppfa_pkg::DIVISOR_W'(5) << 32;

  typedef enum logic [18:0] {
    S_IDLE = 19'd1 << 0,
    S_MX   = 19'd1 << 1,
    S_MY   = 19'd1 << 2,
    S_SQS  = 19'd1 << 3,
    S_SQW  = 19'd1 << 4,
    S_RDEN = 19'd1 << 5,
    S_DIVR = 19'd1 << 6,
    S_WR   = 19'd1 << 7,
    S_MT   = 19'd1 << 8,
    S_DIVS = 19'd1 << 9,
    S_WS   = 19'd1 << 10,
    S_MK   = 19'd1 << 11,
    S_KL   = 19'd1 << 12,
    S_FXM  = 19'd1 << 13,
    S_FXD  = 19'd1 << 14,
    S_FXW  = 19'd1 << 15,
    S_FYM  = 19'd1 << 16,
    S_FYD  = 19'd1 << 17,
    S_FYW  = 19'd1 << 18
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [PW-1:0]  inner_q, outer_q;
  logic [287:0]   coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= ppfa_pkg::INNER_RST;
      outer_q <= ppfa_pkg::OUTER_RST;
      coef_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppfa_pkg::REG_INNER: inner_q <= cfg_wdata_i[PW-1:0];
        ppfa_pkg::REG_OUTER: outer_q <= cfg_wdata_i[PW-1:0];
        ppfa_pkg::REG_COEF0: coef_q[63:0]    <= cfg_wdata_i;
        ppfa_pkg::REG_COEF1: coef_q[127:64]  <= cfg_wdata_i;
        ppfa_pkg::REG_COEF2: coef_q[191:128] <= cfg_wdata_i;
        ppfa_pkg::REG_COEF3: coef_q[255:192] <= cfg_wdata_i;
        ppfa_pkg::REG_COEF4: coef_q[287:256] <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  logic [PW-1:0] in_sx, in_sy, in_ox, in_oy;
  logic [2:0]    in_ks, in_ko;
  logic [1:0]    in_wx, in_wy;

  assign in_sx = s_axis_tdata[14:0];
  assign in_sy = s_axis_tdata[29:15];
  assign in_ks = s_axis_tdata[32:30];
  assign in_ox = s_axis_tdata[47:33];
  assign in_oy = s_axis_tdata[62:48];
  assign in_ko = s_axis_tdata[65:63];
  assign in_wx = s_axis_tdata[67:66];
  assign in_wy = s_axis_tdata[69:68];

  function automatic logic signed [DW-1:0] wrap_shift(input logic [1:0] w,
                                                      input logic signed [DW-1:0] span);
    logic signed [DW-1:0] r;
    begin
      case (w)
        2'b01:   r = span;
        2'b11:   r = -span;
        2'b10:   r = -(span <<< 1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  logic signed [DW-1:0] dx_w, dy_w;
  assign dx_w = $signed(DW'(in_ox)) - wrap_shift(in_wx, WX1) - $signed(DW'(in_sx));
  assign dy_w = $signed(DW'(in_oy)) - wrap_shift(in_wy, WY1) - $signed(DW'(in_sy));

  // Coefficient lookup, zero for a species out of range
  logic [5:0]        cidx;
  logic [7:0]        cbyte;
  logic              ckind_ok;
  assign cidx     = 6'(in_ks) + 6'(in_ko) * 6'(KINDS);
  assign ckind_ok = (32'(in_ks) < KINDS) && (32'(in_ko) < KINDS);
  assign cbyte    = ckind_ok ? coef_q[{cidx, 3'b000} +: 8] : 8'd0;

  // Pair registers
  logic [MW-1:0]  adx_q, ady_q;
  logic           sgnx_q, sgny_q, self_q, last_q;
  logic [7:0]     cabs_q;
  logic           csgn_q;
  logic [RW-1:0]  d_q;
  logic           rep_q, ksgn_q;
  logic [ppfa_pkg::MUL_A_W-1:0]   kmag_q;
  logic [ppfa_pkg::DIVISOR_W-1:0] den_q;
  logic [34:0]    d2x_q;
  logic [ppfa_pkg::QUOT_W-1:0]    r_q, s_q;
  logic signed [ppfa_pkg::F_W-1:0] fx_q, fy_q;

  // Shared multiplier with registered product
  logic [ppfa_pkg::MUL_A_W-1:0] mul_a;
  logic [ppfa_pkg::MUL_B_W-1:0] mul_b;
  logic [ppfa_pkg::PROD_W-1:0]  prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ppfa_pkg::PROD_W'(mul_a) * ppfa_pkg::PROD_W'(mul_b);
  end

  // Shared divider and root unit
  logic                               div_start, div_done;
  logic [ppfa_pkg::DIVIDEND_W-1:0]    div_num;
  logic [ppfa_pkg::DIVISOR_W-1:0]     div_den;
  logic [ppfa_pkg::QUOT_W-1:0]        div_quot;
  logic                               sq_start, sq_done;
  logic [ppfa_pkg::RAD_W-1:0]         sq_rad;
  logic [RW-1:0]                      sq_root;

  ppfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ppfa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  assign sq_rad = ppfa_pkg::RAD_W'(d2x_q) + ppfa_pkg::RAD_W'(prod_q[34:0]);

  // Distance terms used by the branch decision and the divisions
  logic [RW-1:0] inner_ext, d_minus_inner;
  logic [PW-1:0] span;
  logic [30:0]   t_val;
  assign inner_ext     = RW'(inner_q);
  assign d_minus_inner = d_q - inner_ext;
  assign span          = outer_q - inner_q;
  assign t_val         = prod_q[30:0];

  // Output register and accumulators
  logic signed [ppfa_pkg::FORCE_W-1:0] sum_x_q, sum_y_q;
  logic signed [ppfa_pkg::FORCE_W-1:0] nsum_x, nsum_y;
  logic                                out_vld_q;
  logic [47:0]                         out_data_q;
  logic                                acc_go;

  function automatic logic signed [ppfa_pkg::FORCE_W-1:0] sat_add(
      input logic signed [ppfa_pkg::FORCE_W-1:0] acc,
      input logic signed [ppfa_pkg::F_W-1:0]     f);
    logic signed [ppfa_pkg::FORCE_W:0] s;
    begin
      s = (ppfa_pkg::FORCE_W+1)'(acc) + (ppfa_pkg::FORCE_W+1)'(f);
      if (s > 25'sd8388607)       return 24'sh7FFFFF;
      else if (s < -25'sd8388608) return 24'sh800000;
      else                        return s[ppfa_pkg::FORCE_W-1:0];
    end
  endfunction

  assign nsum_x = sat_add(sum_x_q, fx_q);
  assign nsum_y = sat_add(sum_y_q, fy_q);

  // A pair that reaches the y division finishes when that division is done
  assign acc_go = (state_q == S_FYW) && div_done;

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  // Sequencer
  logic fin_pend_q;   // pair done, not yet summed; a last pair also waits for the output register
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_MX;
      S_MX: begin
        mul_a   = ppfa_pkg::MUL_A_W'(adx_q);
        mul_b   = ppfa_pkg::MUL_B_W'(adx_q);
        state_d = S_MY;
      end
      S_MY: begin
        mul_a   = ppfa_pkg::MUL_A_W'(ady_q);
        mul_b   = ppfa_pkg::MUL_B_W'(ady_q);
        state_d = S_SQS;
      end
      S_SQS: begin
        sq_start = 1'b1;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (sq_done) begin
          if (self_q || sq_root == '0) state_d = S_IDLE;
          else if (sq_root < inner_ext) state_d = S_RDEN;
          else if (outer_q <= inner_q) state_d = S_IDLE;
          else if ((sq_root - inner_ext) >= RW'(outer_q - inner_q)) state_d = S_IDLE;
          else state_d = S_DIVR;
        end
      end
      S_RDEN: begin
        mul_a   = ppfa_pkg::MUL_A_W'(inner_q);
        mul_b   = ppfa_pkg::MUL_B_W'(d_q);
        state_d = S_KL;
      end
      S_DIVR: begin
        div_start = 1'b1;
        div_num   = ppfa_pkg::DIVIDEND_W'(d_minus_inner) << 16;
        div_den   = ppfa_pkg::DIVISOR_W'(span);
        state_d   = S_WR;
      end
      S_WR: if (div_done) state_d = S_MT;
      S_MT: begin
        mul_a   = ppfa_pkg::MUL_A_W'(r_q);
        mul_b   = ppfa_pkg::MUL_B_W'(18'd65536 - ppfa_pkg::MUL_B_W'(r_q));
        state_d = S_DIVS;
      end
      S_DIVS: begin
        div_start = 1'b1;
        div_num   = ppfa_pkg::DIVIDEND_W'(t_val) << 19;
        div_den   = BHASK_K - (ppfa_pkg::DIVISOR_W'(t_val) << 2);
        state_d   = S_WS;
      end
      S_WS: if (div_done) state_d = S_MK;
      S_MK: begin
        mul_a   = ppfa_pkg::MUL_A_W'(s_q);
        mul_b   = ppfa_pkg::MUL_B_W'(cabs_q);
        state_d = S_KL;
      end
      S_KL: state_d = S_FXM;
      S_FXM: begin
        mul_a   = kmag_q;
        mul_b   = ppfa_pkg::MUL_B_W'(adx_q);
        state_d = S_FXD;
      end
      S_FXD: begin
        div_start = 1'b1;
        div_num   = ppfa_pkg::DIVIDEND_W'(prod_q);
        div_den   = den_q;
        state_d   = S_FXW;
      end
      S_FXW: if (div_done) state_d = S_FYM;
      S_FYM: begin
        mul_a   = kmag_q;
        mul_b   = ppfa_pkg::MUL_B_W'(ady_q);
        state_d = S_FYD;
      end
      S_FYD: begin
        div_start = 1'b1;
        div_num   = ppfa_pkg::DIVIDEND_W'(prod_q);
        div_den   = den_q;
        state_d   = S_FYW;
      end
      S_FYW: if (div_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Zero-force exits from the root step
  logic zero_exit;
  assign zero_exit = (state_q == S_SQW) && sq_done && (state_d == S_IDLE);

  // A pair finishes on a zero exit or after the y division
  logic pair_done;
  assign pair_done = zero_exit || acc_go;

  assign s_axis_tready = (state_q == S_IDLE) && !fin_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fin_pend_q <= 1'b0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load a finished sum, or drop the valid once the beat is taken
      if (fin_pend_q && last_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (pair_done) fin_pend_q <= 1'b1;
      // Fold the finished pair into the sums, or clear them once a last pair's total is loaded
      if (fin_pend_q) begin
        if (!last_q) begin
          sum_x_q    <= nsum_x;
          sum_y_q    <= nsum_y;
          fin_pend_q <= 1'b0;
        end else if (out_free) begin
          sum_x_q    <= '0;
          sum_y_q    <= '0;
          fin_pend_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      adx_q  <= dx_w[DW-1] ? MW'(-dx_w) : MW'(dx_w);
      ady_q  <= dy_w[DW-1] ? MW'(-dy_w) : MW'(dy_w);
      sgnx_q <= dx_w[DW-1];
      sgny_q <= dy_w[DW-1];
      self_q <= s_axis_tuser;
      last_q <= s_axis_tlast;
      cabs_q <= cbyte[7] ? (8'd0 - cbyte) : cbyte;
      csgn_q <= cbyte[7];
    end
    if (state_q == S_MY) d2x_q <= prod_q[34:0];
    if (state_q == S_SQW && sq_done) begin
      d_q    <= sq_root;
      rep_q  <= sq_root < inner_ext;
      ksgn_q <= 1'b1;
      kmag_q <= ppfa_pkg::MUL_A_W'(inner_ext - sq_root) << 12;
    end
    if (zero_exit) begin
      fx_q <= '0;
      fy_q <= '0;
    end
    if (state_q == S_WR && div_done) r_q <= div_quot;
    if (state_q == S_WS && div_done) s_q <= div_quot;
    if (state_q == S_MK) ksgn_q <= csgn_q;
    if (state_q == S_KL) begin
      if (rep_q) begin
        den_q <= ppfa_pkg::DIVISOR_W'(prod_q[34:0]);
      end else begin
        kmag_q <= prod_q[ppfa_pkg::MUL_A_W-1:0];
        den_q  <= ppfa_pkg::DIVISOR_W'(d_q) << 8;
      end
    end
    if (state_q == S_FXW && div_done) begin
      fx_q <= (ksgn_q ^ sgnx_q) ? -$signed(ppfa_pkg::F_W'(div_quot))
                                :  $signed(ppfa_pkg::F_W'(div_quot));
    end
    if (acc_go) begin
      fy_q <= (ksgn_q ^ sgny_q) ? -$signed(ppfa_pkg::F_W'(div_quot))
                                :  $signed(ppfa_pkg::F_W'(div_quot));
    end
    if (fin_pend_q && last_q && out_free) begin
      out_data_q <= {nsum_y, nsum_x};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
